@@ sv/bswlc_pkg.sv @@
// Package for the byte stream word and line counter.
// Holds count widths, request codes, character codes and small helpers.
// No dependencies.
package bswlc_pkg;

    localparam int CNT_W      = 32;
    localparam int CNT_IDX_W  = $clog2(CNT_W);
    localparam int BCD_DIGITS = (CNT_W * 30103 + 99999) / 100000;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DIG_W      = $clog2(BCD_DIGITS);
    localparam int TAIL_LEN   = 7;
    localparam int TAIL_W     = $clog2(TAIL_LEN);
    localparam int REQ_W      = 2;
    localparam int CHAR_W     = 8;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [CHAR_W-1:0] t_char;

    localparam t_req REQ_DATA  = 2'd0;
    localparam t_req REQ_EOF   = 2'd1;
    localparam t_req REQ_TOTAL = 2'd2;

    localparam t_char CH_ZERO  = 8'd48;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_LF    = 8'h0A;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_T     = 8'h74;
    localparam t_char CH_O     = 8'h6F;
    localparam t_char CH_A     = 8'h61;
    localparam t_char CH_L     = 8'h6C;

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic is_space(input t_char c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    // " total\n"; the file line starts at the final newline
    function automatic t_char tail_char(input logic [TAIL_W-1:0] idx);
        t_char c;
        case (idx)
            3'd0:    c = CH_SPACE;
            3'd1:    c = CH_T;
            3'd2:    c = CH_O;
            3'd3:    c = CH_T;
            3'd4:    c = CH_A;
            3'd5:    c = CH_L;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

endpackage

@@ sv/byte_stream_word_line_counter_core.sv @@
// Byte stream word, line and byte counter with decimal text output.
// Single module; depends on bswlc_pkg.
//
// Input channel s_axis: one transfer per request. tuser holds the request
// kind (data byte, end of file, totals), tdata the byte. Data bytes are taken
// one per cycle while no line is being formatted. End of file folds the file
// counts into the totals, clears them and starts "L W B\n"; totals starts
// "L W B total\n". Counts saturate at all ones.
// Output channel m_axis: one character per transfer, tlast on the newline.
// Each number is converted by a bit-serial double-dabble shifter, one bit per
// cycle, then its 10 BCD digits are scanned one per cycle, leading zeros
// skipped; a digit to be shown waits while the receiver stalls.
// s_axis_tready is high only while no line is in progress; the final character
// may still wait in the output register while new bytes are taken.
// A stalled receiver holds the current character; the formatter waits to emit.
// Reset clears all counts, totals and the word flag, and empties the output.
module byte_stream_word_line_counter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
    input  logic [bswlc_pkg::REQ_W-1:0] s_axis_tuser, // [1:0] req_type
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [7:0] out_char
    output logic                       m_axis_tlast   // last_char
);
    import bswlc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT,
        ST_SEP,
        ST_TAIL
    } t_state;

    t_state                r_state,  n_state;
    logic                  r_inword, n_inword;
    t_cnt                  r_flines, n_flines;
    t_cnt                  r_fwords, n_fwords;
    t_cnt                  r_fbytes, n_fbytes;
    t_cnt                  r_slines, n_slines;
    t_cnt                  r_swords, n_swords;
    t_cnt                  r_sbytes, n_sbytes;
    t_cnt                  r_val [3];
    t_cnt                  n_val [3];
    logic [1:0]            r_fld,    n_fld;
    logic                  r_total,  n_total;
    t_cnt                  r_shift,  n_shift;
    logic [BCD_W-1:0]      r_bcd,    n_bcd;
    logic [CNT_IDX_W-1:0]  r_cnt,    n_cnt;
    logic [DIG_W-1:0]      r_dig,    n_dig;
    logic                  r_seen,   n_seen;
    logic [TAIL_W-1:0]     r_tidx,   n_tidx;
    logic                  r_mvalid, n_mvalid;
    t_char                 r_mdata,  n_mdata;
    logic                  r_mlast,  n_mlast;

    logic                  slot_free;
    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_dig;
    logic                  dig_last;
    logic                  need_out;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;

    assign slot_free = !r_mvalid || m_axis_tready;
    assign top_dig   = r_bcd[BCD_W-1 -: 4];
    assign dig_last  = (r_dig == DIG_W'(BCD_DIGITS - 1));
    assign need_out  = (top_dig != 4'd0) || r_seen || dig_last;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ?
                                r_bcd[4*i +: 4] + 4'd3 : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_inword = r_inword;
        n_flines = r_flines;
        n_fwords = r_fwords;
        n_fbytes = r_fbytes;
        n_slines = r_slines;
        n_swords = r_swords;
        n_sbytes = r_sbytes;
        n_val    = r_val;
        n_fld    = r_fld;
        n_total  = r_total;
        n_shift  = r_shift;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_dig    = r_dig;
        n_seen   = r_seen;
        n_tidx   = r_tidx;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        n_mlast  = r_mlast;

        if (r_mvalid && m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        REQ_DATA: begin
                            n_fbytes = sat_add(r_fbytes, t_cnt'(1));
                            if (is_space(s_axis_tdata)) begin
                                n_inword = 1'b0;
                            end else if (!r_inword) begin
                                n_fwords = sat_add(r_fwords, t_cnt'(1));
                                n_inword = 1'b1;
                            end
                            if (s_axis_tdata == CH_LF) begin
                                n_flines = sat_add(r_flines, t_cnt'(1));
                            end
                        end
                        REQ_EOF: begin
                            n_slines = sat_add(r_slines, r_flines);
                            n_swords = sat_add(r_swords, r_fwords);
                            n_sbytes = sat_add(r_sbytes, r_fbytes);
                            n_val[0] = r_flines;
                            n_val[1] = r_fwords;
                            n_val[2] = r_fbytes;
                            n_shift  = r_flines;
                            n_flines = '0;
                            n_fwords = '0;
                            n_fbytes = '0;
                            n_inword = 1'b0;
                            n_total  = 1'b0;
                            n_fld    = 2'd0;
                            n_bcd    = '0;
                            n_cnt    = '0;
                            n_state  = ST_CONV;
                        end
                        REQ_TOTAL: begin
                            n_val[0] = r_slines;
                            n_val[1] = r_swords;
                            n_val[2] = r_sbytes;
                            n_shift  = r_slines;
                            n_total  = 1'b1;
                            n_fld    = 2'd0;
                            n_bcd    = '0;
                            n_cnt    = '0;
                            n_state  = ST_CONV;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CONV: begin
                n_bcd   = {bcd_adj[BCD_W-2:0], r_shift[CNT_W-1]};
                n_shift = {r_shift[CNT_W-2:0], 1'b0};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_IDX_W'(CNT_W - 1)) begin
                    n_dig   = '0;
                    n_seen  = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!need_out || slot_free) begin
                    if (need_out) begin
                        n_mvalid = 1'b1;
                        n_mdata  = CH_ZERO + {4'd0, top_dig};
                        n_mlast  = 1'b0;
                        n_seen   = 1'b1;
                    end
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig = r_dig + 1'b1;
                    if (dig_last) begin
                        if (r_fld == 2'd2) begin
                            n_tidx  = r_total ? '0 : TAIL_W'(TAIL_LEN - 1);
                            n_state = ST_TAIL;
                        end else begin
                            n_state = ST_SEP;
                        end
                    end
                end
            end
            ST_SEP: begin
                if (slot_free) begin
                    n_mvalid = 1'b1;
                    n_mdata  = CH_SPACE;
                    n_mlast  = 1'b0;
                    n_fld    = r_fld + 1'b1;
                    n_shift  = r_val[r_fld + 1'b1];
                    n_bcd    = '0;
                    n_cnt    = '0;
                    n_state  = ST_CONV;
                end
            end
            ST_TAIL: begin
                if (slot_free) begin
                    n_mvalid = 1'b1;
                    n_mdata  = tail_char(r_tidx);
                    n_mlast  = (r_tidx == TAIL_W'(TAIL_LEN - 1));
                    if (r_tidx == TAIL_W'(TAIL_LEN - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_tidx = r_tidx + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_inword <= 1'b0;
            r_flines <= '0;
            r_fwords <= '0;
            r_fbytes <= '0;
            r_slines <= '0;
            r_swords <= '0;
            r_sbytes <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inword <= n_inword;
            r_flines <= n_flines;
            r_fwords <= n_fwords;
            r_fbytes <= n_fbytes;
            r_slines <= n_slines;
            r_swords <= n_swords;
            r_sbytes <= n_sbytes;
            r_mvalid <= n_mvalid;
        end
        r_val   <= n_val;
        r_fld   <= n_fld;
        r_total <= n_total;
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_dig   <= n_dig;
        r_seen  <= n_seen;
        r_tidx  <= n_tidx;
        r_mdata <= n_mdata;
        r_mlast <= n_mlast;
    end

endmodule
